// ===== design/cnl_pkg.sv =====
package cnl_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int LEVEL_W     = 32;
  localparam int CODE_W      = 16;
  localparam int IDX_W       = 8;
  localparam int CFG_W       = 9;
  localparam int SUM_W       = 34;

  // common width for range checks against the table depth
  localparam int CHK_W       = (CFG_W > CNT_W) ? ((CFG_W > IDX_W) ? CFG_W : IDX_W)
                                               : ((CNT_W > IDX_W) ? CNT_W : IDX_W);

  localparam logic [CFG_W-1:0] ENTRIES_RESET = CFG_W'(256);

  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  typedef logic [ADDR_W-1:0]         addr_t;
  typedef logic signed [LEVEL_W-1:0] level_t;
  typedef logic [CODE_W-1:0]         code_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DECIDE
  } state_t;

  typedef struct packed {
    logic   en;
    addr_t  addr;
    level_t level;
    code_t  code;
  } wr_port_t;

endpackage

// ===== design/cnl_in_if.sv =====
interface cnl_in_if;
  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic [cnl_pkg::IDX_W-1:0]     entry_index;
  logic signed [cnl_pkg::LEVEL_W-1:0] entry_level;
  logic [cnl_pkg::CODE_W-1:0]    entry_code;
  logic signed [cnl_pkg::LEVEL_W-1:0] query_value;

  modport source (output valid, req_type, entry_index, entry_level, entry_code, query_value,
                  input ready);
  modport sink   (input valid, req_type, entry_index, entry_level, entry_code, query_value,
                  output ready);
endinterface

// ===== design/cnl_out_if.sv =====
interface cnl_out_if;
  logic                       valid;
  logic                       ready;
  logic [cnl_pkg::CODE_W-1:0] matched_code;

  modport source (output valid, matched_code, input ready);
  modport sink   (input valid, matched_code, output ready);
endinterface

// ===== design/calibration_nearest_lookup.sv =====
// Channel   Dir  Beat contents
// in_ch     in   req_type, entry_index, entry_level, entry_code, query_value
// out_ch    out  matched_code (one beat per lookup, none per table write)
// cfg       in   cfg_we / cfg_wdata: entries_used
//
// A table write lands in the table at acceptance. A lookup of zero goes from acceptance
// straight to its decide step; any other lookup walks the entries from entry 0 and stops
// at the first entry i whose level is not below the query value or at the last active
// entry, then decides, with the single table read port feeding the shared compare one entry
// per cycle. in_ch.ready is low from a lookup's acceptance until its result is registered.
// Reset clears control state only; table entries hold nothing until written.
// The result register holds its beat while out_ch.ready is low; a following lookup waits
// in its decide step until the register is free.
module calibration_nearest_lookup (
  input  logic                        clk,
  input  logic                        rst_n,
  cnl_in_if.sink                      in_ch,
  cnl_out_if.source                   out_ch,
  input  logic                        cfg_we,
  input  logic [cnl_pkg::CFG_W-1:0]   cfg_wdata
);

  cnl_pkg::state_t state_r, state_nxt;

  logic [cnl_pkg::CFG_W-1:0] entries_r;
  cnl_pkg::addr_t            cur_r;
  cnl_pkg::level_t           val_r;
  logic                      zero_r;
  cnl_pkg::level_t           prev_lvl_r, cur_lvl_r;
  cnl_pkg::code_t            prev_code_r, cur_code_r;
  logic                      out_valid_r;
  cnl_pkg::code_t            out_code_r;

  cnl_pkg::wr_port_t         wr;
  cnl_pkg::addr_t            rd_addr;
  cnl_pkg::level_t           rd_level;
  cnl_pkg::code_t            rd_code;

  logic signed [cnl_pkg::SUM_W-1:0] cmp_lhs;
  cnl_pkg::level_t           cmp_rhs_a, cmp_rhs_b;
  logic                      cmp_lt;

  logic [cnl_pkg::CHK_W-1:0] cfg_ext, cnt_ext, idx_ext;
  cnl_pkg::addr_t            last_idx;
  logic                      in_acc, lookup_acc, walk_stop, slot_free, finish;
  cnl_pkg::code_t            result_code;

  // active entry count: zero counts as one, saturate at the table depth
  always_comb begin
    cfg_ext = cnl_pkg::CHK_W'(entries_r);
    if (cfg_ext == '0) begin
      cnt_ext = cnl_pkg::CHK_W'(1);
    end else if (cfg_ext > cnl_pkg::CHK_W'(cnl_pkg::TABLE_DEPTH)) begin
      cnt_ext = cnl_pkg::CHK_W'(cnl_pkg::TABLE_DEPTH);
    end else begin
      cnt_ext = cfg_ext;
    end
    last_idx = cnl_pkg::ADDR_W'(cnt_ext - cnl_pkg::CHK_W'(1));
  end

  assign in_acc     = in_ch.valid && in_ch.ready;
  assign lookup_acc = in_acc && (in_ch.req_type == cnl_pkg::REQ_LOOKUP);
  assign idx_ext    = cnl_pkg::CHK_W'(in_ch.entry_index);

  always_comb begin
    wr.en    = in_acc && (in_ch.req_type == cnl_pkg::REQ_WRITE) &&
               (idx_ext < cnl_pkg::CHK_W'(cnl_pkg::TABLE_DEPTH));
    wr.addr  = cnl_pkg::ADDR_W'(in_ch.entry_index);
    wr.level = in_ch.entry_level;
    wr.code  = in_ch.entry_code;
  end

  cnl_table u_table (
    .clk      (clk),
    .wr       (wr),
    .rd_addr  (rd_addr),
    .rd_level (rd_level),
    .rd_code  (rd_code)
  );

  cnl_cmp u_cmp (
    .lhs   (cmp_lhs),
    .rhs_a (cmp_rhs_a),
    .rhs_b (cmp_rhs_b),
    .lt    (cmp_lt)
  );

  // in the walk the unit asks level < value; in decide it asks 2*value < prev + cur
  assign walk_stop = !cmp_lt || (cur_r == last_idx);
  assign slot_free = !out_valid_r || out_ch.ready;
  assign finish    = (state_r == cnl_pkg::ST_DECIDE) && slot_free;

  always_comb begin
    if (zero_r) begin
      result_code = '0;
    end else if ((cur_r != '0) && cmp_lt) begin
      result_code = prev_code_r;
    end else begin
      result_code = cur_code_r;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cnl_pkg::ST_IDLE: begin
        if (lookup_acc) begin
          state_nxt = (in_ch.query_value == '0) ? cnl_pkg::ST_DECIDE : cnl_pkg::ST_WALK;
        end
      end
      cnl_pkg::ST_WALK: begin
        if (walk_stop) begin
          state_nxt = cnl_pkg::ST_DECIDE;
        end
      end
      cnl_pkg::ST_DECIDE: begin
        if (slot_free) begin
          state_nxt = cnl_pkg::ST_IDLE;
        end
      end
      default: state_nxt = cnl_pkg::ST_IDLE;
    endcase
  end

  // outputs: read address, compare operands, input ready
  always_comb begin
    in_ch.ready = 1'b0;
    rd_addr     = '0;
    cmp_lhs     = '0;
    cmp_rhs_a   = '0;
    cmp_rhs_b   = '0;
    unique case (state_r)
      cnl_pkg::ST_IDLE: begin
        in_ch.ready = 1'b1;
      end
      cnl_pkg::ST_WALK: begin
        rd_addr   = cur_r + cnl_pkg::ADDR_W'(1);
        cmp_lhs   = cnl_pkg::SUM_W'(rd_level);
        cmp_rhs_a = val_r;
      end
      cnl_pkg::ST_DECIDE: begin
        rd_addr   = cur_r;
        cmp_lhs   = {val_r[cnl_pkg::LEVEL_W-1], val_r, 1'b0};
        cmp_rhs_a = prev_lvl_r;
        cmp_rhs_b = cur_lvl_r;
      end
      default: begin
        in_ch.ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cnl_pkg::ST_IDLE;
      entries_r   <= cnl_pkg::ENTRIES_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        entries_r <= cfg_wdata;
      end
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (lookup_acc) begin
      val_r  <= in_ch.query_value;
      zero_r <= (in_ch.query_value == '0);
      cur_r  <= '0;
    end
    if (state_r == cnl_pkg::ST_WALK) begin
      if (walk_stop) begin
        // hold the stop entry for the midpoint test
        cur_lvl_r  <= rd_level;
        cur_code_r <= rd_code;
      end else begin
        prev_lvl_r  <= rd_level;
        prev_code_r <= rd_code;
        cur_r       <= cur_r + cnl_pkg::ADDR_W'(1);
      end
    end
    if (finish) begin
      out_code_r <= result_code;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.matched_code = out_code_r;

endmodule

// ===== design/cnl_table.sv =====
module cnl_table (
  input  logic              clk,
  input  cnl_pkg::wr_port_t wr,
  input  cnl_pkg::addr_t    rd_addr,
  output cnl_pkg::level_t   rd_level,
  output cnl_pkg::code_t    rd_code
);

  cnl_pkg::level_t level_mem [cnl_pkg::TABLE_DEPTH];
  cnl_pkg::code_t  code_mem  [cnl_pkg::TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      level_mem[wr.addr] <= wr.level;
      code_mem[wr.addr]  <= wr.code;
    end
  end

  always_ff @(posedge clk) begin
    rd_level <= level_mem[rd_addr];
    rd_code  <= code_mem[rd_addr];
  end

endmodule

// ===== design/cnl_cmp.sv =====
module cnl_cmp (
  input  logic signed [cnl_pkg::SUM_W-1:0]   lhs,
  input  logic signed [cnl_pkg::LEVEL_W-1:0] rhs_a,
  input  logic signed [cnl_pkg::LEVEL_W-1:0] rhs_b,
  output logic                               lt
);

  logic signed [cnl_pkg::SUM_W-1:0] rhs_sum;

  assign rhs_sum = cnl_pkg::SUM_W'(rhs_a) + cnl_pkg::SUM_W'(rhs_b);
  assign lt      = lhs < rhs_sum;

endmodule
